@@ hw/rtl/ring_queue_with_head_push_assert.svh @@
// Assertion macros shared by the ring queue modules.
`ifndef RING_QUEUE_WITH_HEAD_PUSH_ASSERT_SVH
`define RING_QUEUE_WITH_HEAD_PUSH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RQHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rqhp_pkg.sv @@
package rqhp_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [COUNT_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_DRAIN = 3'd3,
        OP_PUSH  = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic exec_more;
        logic last_pop;
        logic count_nz;
    } stat_t;

endpackage

@@ hw/rtl/rqhp_ctrl.sv @@
`include "ring_queue_with_head_push_assert.svh"

module rqhp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rqhp_pkg::stat_t stat,
    output rqhp_pkg::cmd_t  cmd
);

    rqhp_pkg::state_t state_reg;
    rqhp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqhp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rqhp_pkg::S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.accept = 1'b1;
                    state_next = rqhp_pkg::S_EXEC;
                end
            end
            rqhp_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.exec_more)
                begin
                    state_next = rqhp_pkg::S_DRAIN;
                end
                else
                begin
                    state_next = rqhp_pkg::S_IDLE;
                end
            end
            rqhp_pkg::S_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (stat.last_pop)
                    begin
                        state_next = rqhp_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rqhp_pkg::S_IDLE;
            end
        endcase
    end

    `RQHP_ASSERT_SAME(a_exec_out_free, clk, rst_n,
        state_reg == rqhp_pkg::S_EXEC, stat.out_free,
        "result register busy when an item executes")
    `RQHP_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd.pop, stat.count_nz,
        "drain step on an empty queue")
    `RQHP_ASSERT_NEXT(a_accept_exec, clk, rst_n, cmd.accept,
        state_reg == rqhp_pkg::S_EXEC, "accepted item not executed in the next cycle")

endmodule

@@ hw/rtl/rqhp_dp.sv @@
`include "ring_queue_with_head_push_assert.svh"

module rqhp_dp
#(
    parameter int DEPTH      = 32,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rqhp_pkg::cmd_t                      cmd,
    output rqhp_pkg::stat_t                     stat,
    input  logic                                cfg_wr_en,
    input  logic [rqhp_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic [rqhp_pkg::OP_W-1:0]           opcode,
    input  logic [rqhp_pkg::DATA_W-1:0]         item_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rqhp_pkg::STAT_W-1:0]         status,
    output logic [rqhp_pkg::DATA_W-1:0]         item_out,
    output logic                                evicted_valid,
    output logic [rqhp_pkg::DATA_W-1:0]         evicted_item,
    output logic                                last,
    output logic [rqhp_pkg::COUNT_W-1:0]        occupancy,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int CW = rqhp_pkg::COUNT_W;
    localparam int DW = rqhp_pkg::DATA_W;
    localparam int SW = (ITEM_WIDTH < DW) ? ITEM_WIDTH : DW;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

    logic [SW-1:0] mem [DEPTH];

    logic [CW-1:0] cap_reg;
    logic [CW-1:0] front_reg;
    logic [CW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [rqhp_pkg::OP_W-1:0] op_reg;
    logic [SW-1:0] item_reg;
    logic [SW-1:0] rd_data_reg;

    logic                  out_valid_reg;
    logic [rqhp_pkg::STAT_W-1:0] status_reg;
    logic [DW-1:0]         item_out_reg;
    logic                  ev_valid_reg;
    logic [DW-1:0]         ev_item_reg;
    logic                  last_reg;
    logic [CW-1:0]         occ_reg;
    logic                  empty_reg;
    logic                  full_reg;

    logic [CW-1:0] cap_eff;
    logic [CW:0]   tail_sum;
    logic [CW-1:0] tail_slot;
    logic [CW:0]   inc_sum;
    logic [CW-1:0] front_inc;
    logic [CW-1:0] front_dec;
    logic          q_empty;
    logic          q_full;
    logic          pop_now;
    logic [CW-1:0] rd_slot;
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic          load_out;

    rqhp_pkg::status_t res_status;
    logic [DW-1:0]     res_item;
    logic              res_ev_valid;
    logic [DW-1:0]     res_ev_item;
    logic              res_last;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if ({1'b0, cap_reg} > DEPTH_W)
        begin
            cap_eff = DEPTH_W[CW-1:0];
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign tail_sum  = {1'b0, front_reg} + {1'b0, count_reg};
    assign tail_slot = (tail_sum >= {1'b0, cap_eff}) ? CW'(tail_sum - {1'b0, cap_eff})
                                                     : tail_sum[CW-1:0];
    assign inc_sum   = {1'b0, front_reg} + (CW + 1)'(1);
    assign front_inc = (inc_sum == {1'b0, cap_eff}) ? '0 : inc_sum[CW-1:0];
    assign front_dec = (front_reg == '0) ? (cap_eff - CW'(1)) : (front_reg - CW'(1));
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg >= cap_eff);

    assign pop_now = cmd.pop
                     || (cmd.exec && !q_empty
                         && ((op_reg == rqhp_pkg::OP_DEQ) || (op_reg == rqhp_pkg::OP_DRAIN)));

    always_comb
    begin
        if (cmd.accept && (opcode == rqhp_pkg::OP_PUSH))
        begin
            rd_slot = front_dec;
        end
        else if (pop_now)
        begin
            rd_slot = front_inc;
        end
        else
        begin
            rd_slot = front_reg;
        end
    end

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        mem_waddr    = tail_slot;
        res_status   = rqhp_pkg::ST_OK;
        res_item     = '0;
        res_ev_valid = 1'b0;
        res_ev_item  = '0;
        res_last     = 1'b1;
        if (cmd.exec)
        begin
            case (op_reg)
                rqhp_pkg::OP_ENQ:
                begin
                    if (q_full)
                    begin
                        res_status = rqhp_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                rqhp_pkg::OP_DEQ:
                begin
                    if (q_empty)
                    begin
                        res_status = rqhp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_item   = DW'(rd_data_reg);
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                rqhp_pkg::OP_PEEK:
                begin
                    if (q_empty)
                    begin
                        res_status = rqhp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_item = DW'(rd_data_reg);
                    end
                end
                rqhp_pkg::OP_DRAIN:
                begin
                    if (q_empty)
                    begin
                        res_status = rqhp_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_item   = DW'(rd_data_reg);
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                        res_last   = (count_reg == CW'(1));
                    end
                end
                rqhp_pkg::OP_PUSH:
                begin
                    front_next = front_dec;
                    mem_we     = 1'b1;
                    mem_waddr  = front_dec;
                    if (q_full)
                    begin
                        res_ev_valid = 1'b1;
                        res_ev_item  = DW'(rd_data_reg);
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                default:
                begin
                    res_status = rqhp_pkg::ST_OK;
                end
            endcase
        end
        if (cmd.pop)
        begin
            res_item   = DW'(rd_data_reg);
            front_next = front_inc;
            count_next = count_reg - CW'(1);
            res_last   = (count_reg == CW'(1));
        end
        if (cfg_wr_en)
        begin
            front_next = '0;
            count_next = '0;
        end
    end

    assign load_out = cmd.exec || cmd.pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= rqhp_pkg::CAP_RESET;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            front_reg <= front_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            item_reg <= item_in[SW-1:0];
        end
        if (load_out)
        begin
            status_reg   <= res_status;
            item_out_reg <= res_item;
            ev_valid_reg <= res_ev_valid;
            ev_item_reg  <= res_ev_item;
            last_reg     <= res_last;
            occ_reg      <= count_next;
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next == cap_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr[AW-1:0]] <= item_reg;
        end
        rd_data_reg <= mem[rd_slot[AW-1:0]];
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.exec_more = (op_reg == rqhp_pkg::OP_DRAIN) && (count_reg > CW'(1));
    assign stat.last_pop  = (count_reg == CW'(1));
    assign stat.count_nz  = !q_empty;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign item_out      = item_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_item  = ev_item_reg;
    assign last          = last_reg;
    assign occupancy     = occ_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

    `RQHP_ASSERT_SAME(a_count_in_cap, clk, rst_n, 1'b1, count_reg <= cap_eff, "occupancy exceeds capacity")
    `RQHP_ASSERT_SAME(a_front_in_cap, clk, rst_n, 1'b1, front_reg < cap_eff, "head slot outside the ring")
    `RQHP_ASSERT_NEXT(a_evict_keeps_count, clk, rst_n, cmd.exec && (op_reg == rqhp_pkg::OP_PUSH) && q_full && !cfg_wr_en, $stable(count_reg), "eviction changed the occupancy")

endmodule

@@ hw/rtl/ring_queue_with_head_push.sv @@
// Channel  Direction  Handshake             Fields
// in       input      in_valid / in_ready   opcode, item_in
// out      output     out_valid / out_ready status, item_out, evicted_valid, evicted_item,
//                                           last, occupancy, is_empty, is_full
// cfg      input      cfg_wr_en             cfg_wr_data (capacity)
//
// The item store is read at the accepting edge and the item executes in the next cycle,
// loading the output register. With out_ready high, a new item is accepted only once the
// previous one has executed or finished draining, and a drain of n items gives n results,
// one per cycle.
// A stall on out_ready holds the result and blocks the next item until the result is taken.
// Reset empties the queue and sets the capacity to 32; the item store is not cleared.
module ring_queue_with_head_push
#(
    parameter int DEPTH      = 32,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rqhp_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rqhp_pkg::OP_W-1:0]     opcode,
    input  logic [rqhp_pkg::DATA_W-1:0]   item_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rqhp_pkg::STAT_W-1:0]   status,
    output logic [rqhp_pkg::DATA_W-1:0]   item_out,
    output logic                          evicted_valid,
    output logic [rqhp_pkg::DATA_W-1:0]   evicted_item,
    output logic                          last,
    output logic [rqhp_pkg::COUNT_W-1:0]  occupancy,
    output logic                          is_empty,
    output logic                          is_full
);

    rqhp_pkg::cmd_t  cmd;
    rqhp_pkg::stat_t stat;

    rqhp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqhp_dp
    #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .opcode        (opcode),
        .item_in       (item_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .item_out      (item_out),
        .evicted_valid (evicted_valid),
        .evicted_item  (evicted_item),
        .last          (last),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

typedef struct packed {
    rqhp_pkg::status_t                 status;
    logic [rqhp_pkg::DATA_W-1:0]       item_out;
    logic                              evicted_valid;
    logic [rqhp_pkg::DATA_W-1:0]       evicted_item;
    logic                              last;
    logic [rqhp_pkg::COUNT_W-1:0]      occupancy;
    logic                              is_empty;
    logic                              is_full;
} queue_result_t;

class queue_tracker;
    logic [rqhp_pkg::DATA_W-1:0]   slots [32];
    int unsigned                   head;
    int unsigned                   count;
    logic [rqhp_pkg::COUNT_W-1:0]  cap_reg;
    queue_result_t                 awaited_results [$];
    int unsigned                   mismatches;
    int unsigned                   checked;
    int unsigned                   evictions;
    int unsigned                   drains;
    int unsigned                   full_refusals;
    int unsigned                   empty_replies;

    function new();
        head = 0;
        count = 0;
        cap_reg = rqhp_pkg::CAP_RESET;
        mismatches = 0;
        checked = 0;
        evictions = 0;
        drains = 0;
        full_refusals = 0;
        empty_replies = 0;
    endfunction

    function int unsigned limit();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > 32)
            return 32;
        return cap_reg;
    endfunction

    function void write_capacity(logic [rqhp_pkg::COUNT_W-1:0] value);
        cap_reg = value;
        head = 0;
        count = 0;
    endfunction

    function void add_result(rqhp_pkg::status_t st, logic [rqhp_pkg::DATA_W-1:0] data,
                             logic ev_valid, logic [rqhp_pkg::DATA_W-1:0] ev_data,
                             logic is_last);
        queue_result_t r;
        r.status = st;
        r.item_out = data;
        r.evicted_valid = ev_valid;
        r.evicted_item = ev_data;
        r.last = is_last;
        r.occupancy = count[rqhp_pkg::COUNT_W-1:0];
        r.is_empty = (count == 0);
        r.is_full = (count == limit());
        if (st == rqhp_pkg::ST_FULL)
            full_refusals++;
        if (st == rqhp_pkg::ST_EMPTY)
            empty_replies++;
        awaited_results.push_back(r);
    endfunction

    function void note_op(logic [rqhp_pkg::OP_W-1:0] op, logic [rqhp_pkg::DATA_W-1:0] data);
        int unsigned lim;
        logic [rqhp_pkg::DATA_W-1:0] word;
        logic ev_valid;
        logic [rqhp_pkg::DATA_W-1:0] ev_data;
        lim = limit();
        case (op)
            rqhp_pkg::OP_ENQ:
                if (count >= lim)
                    add_result(rqhp_pkg::ST_FULL, '0, 1'b0, '0, 1'b1);
                else
                begin
                    slots[(head + count) % lim] = data;
                    count++;
                    add_result(rqhp_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
                end
            rqhp_pkg::OP_DEQ, rqhp_pkg::OP_PEEK:
                if (count == 0)
                    add_result(rqhp_pkg::ST_EMPTY, '0, 1'b0, '0, 1'b1);
                else
                begin
                    word = slots[head];
                    if (op == rqhp_pkg::OP_DEQ)
                    begin
                        head = (head + 1) % lim;
                        count--;
                    end
                    add_result(rqhp_pkg::ST_OK, word, 1'b0, '0, 1'b1);
                end
            rqhp_pkg::OP_DRAIN:
                if (count == 0)
                    add_result(rqhp_pkg::ST_EMPTY, '0, 1'b0, '0, 1'b1);
                else
                begin
                    drains++;
                    while (count > 0)
                    begin
                        word = slots[head];
                        head = (head + 1) % lim;
                        count--;
                        add_result(rqhp_pkg::ST_OK, word, 1'b0, '0, count == 0);
                    end
                end
            rqhp_pkg::OP_PUSH:
            begin
                ev_valid = 1'b0;
                ev_data = '0;
                if (count >= lim)
                begin
                    ev_data = slots[(head + count - 1) % lim];
                    ev_valid = 1'b1;
                    count--;
                    evictions++;
                end
                head = (head + lim - 1) % lim;
                slots[head] = data;
                count++;
                add_result(rqhp_pkg::ST_OK, '0, ev_valid, ev_data, 1'b1);
            end
            default:
                add_result(rqhp_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    function void check_result(queue_result_t got);
        queue_result_t want;
        checked++;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result: status %0d item %h last %b occ %0d",
                         $realtime, got.status, got.item_out, got.last, got.occupancy);
            return;
        end
        want = awaited_results.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: expected st %0d item %h ev %b/%h last %b occ %0d e %b f %b",
                         $realtime, want.status, want.item_out, want.evicted_valid,
                         want.evicted_item, want.last, want.occupancy, want.is_empty,
                         want.is_full);
                $display("%0t: actual   st %0d item %h ev %b/%h last %b occ %0d e %b f %b",
                         $realtime, got.status, got.item_out, got.evicted_valid,
                         got.evicted_item, got.last, got.occupancy, got.is_empty,
                         got.is_full);
            end
        end
    endfunction
endclass

module tb;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rqhp_pkg::COUNT_W-1:0]   cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [rqhp_pkg::OP_W-1:0]      opcode = rqhp_pkg::OP_ENQ;
    logic [rqhp_pkg::DATA_W-1:0]    item_in = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [rqhp_pkg::STAT_W-1:0]    status;
    logic [rqhp_pkg::DATA_W-1:0]    item_out;
    logic                           evicted_valid;
    logic [rqhp_pkg::DATA_W-1:0]    evicted_item;
    logic                           last;
    logic [rqhp_pkg::COUNT_W-1:0]   occupancy;
    logic                           is_empty;
    logic                           is_full;

    queue_tracker         tracker;
    logic                 in_taken = 1'b0;
    int unsigned          ready_pct = 100;
    bit                   hold_request = 1'b0;
    bit                   hold_done = 1'b0;
    int unsigned          hold_left = 0;
    int unsigned          items_sent = 0;
    int unsigned          cap_settings = 0;

    ring_queue_with_head_push dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .item_in       (item_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .item_out      (item_out),
        .evicted_valid (evicted_valid),
        .evicted_item  (evicted_item),
        .last          (last),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    always #6 clk = ~clk;

    // Handshakes are sampled on the falling clock edge, after the rising edge that drove them.
    always @(negedge clk)
    begin
        queue_result_t got;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            tracker.note_op(opcode, item_in);
        if (rst_n && out_valid && out_ready)
        begin
            got.status = rqhp_pkg::status_t'(status);
            got.item_out = item_out;
            got.evicted_valid = evicted_valid;
            got.evicted_item = evicted_item;
            got.last = last;
            got.occupancy = occupancy;
            got.is_empty = is_empty;
            got.is_full = is_full;
            tracker.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) < ready_pct);
    end

    task automatic send_item(input logic [rqhp_pkg::OP_W-1:0] op,
                             input logic [rqhp_pkg::DATA_W-1:0] data);
        in_valid <= 1'b1;
        opcode <= op;
        item_in <= data;
        @(posedge clk);
        while (!in_taken)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle();
        pause_sender(1);
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [rqhp_pkg::COUNT_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.write_capacity(value);
        cap_settings++;
    endtask

    function automatic logic [rqhp_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Codes above the push opcode are unused and must leave the queue alone.
    function automatic logic [rqhp_pkg::OP_W-1:0] spare_op(input int unsigned k);
        return (rqhp_pkg::OP_W)'(int'(rqhp_pkg::OP_PUSH) + k);
    endfunction

    function automatic logic [rqhp_pkg::OP_W-1:0] pick_op(input int unsigned fill_pct);
        int unsigned r;
        if ($urandom_range(99) < fill_pct)
            return ($urandom_range(2) == 0) ? rqhp_pkg::OP_PUSH : rqhp_pkg::OP_ENQ;
        r = $urandom_range(99);
        if (r < 25)
            return rqhp_pkg::OP_DEQ;
        if (r < 40)
            return rqhp_pkg::OP_PEEK;
        if (r < 52)
            return rqhp_pkg::OP_DRAIN;
        if (r < 60)
            return spare_op($urandom_range(1, 3));
        if (r < 80)
            return rqhp_pkg::OP_ENQ;
        return rqhp_pkg::OP_PUSH;
    endfunction

    task automatic run_phase(input logic [rqhp_pkg::COUNT_W-1:0] cap,
                             input int unsigned count, input int unsigned fill_pct,
                             input int unsigned ready);
        int unsigned sent;
        int unsigned burst;
        set_capacity(cap);
        ready_pct = ready;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            if (burst > count - sent)
                burst = count - sent;
            repeat (burst)
            begin
                send_item(pick_op(fill_pct), random_word());
                sent++;
            end
            if ($urandom_range(3) != 0)
                pause_sender($urandom_range(1, 5));
        end
        settle();
    endtask

    initial
    begin
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        ready_pct = 100;
        send_item(rqhp_pkg::OP_PEEK, 32'h0);
        send_item(rqhp_pkg::OP_DEQ, 32'h0);
        send_item(rqhp_pkg::OP_DRAIN, 32'h0);
        send_item(rqhp_pkg::OP_ENQ, 32'h0000_0000);
        send_item(rqhp_pkg::OP_ENQ, 32'hFFFF_FFFF);
        send_item(rqhp_pkg::OP_ENQ, 32'hA5A5_A5A5);
        send_item(rqhp_pkg::OP_PEEK, 32'h0);
        send_item(rqhp_pkg::OP_PUSH, 32'h1234_5678);
        send_item(rqhp_pkg::OP_DEQ, 32'h0);
        send_item(spare_op(1), 32'h5A5A_5A5A);
        send_item(spare_op(2), 32'hFFFF_FFFF);
        send_item(spare_op(3), 32'h0);
        send_item(rqhp_pkg::OP_DRAIN, 32'h0);

        set_capacity(6'd1);
        ready_pct = 60;
        send_item(rqhp_pkg::OP_ENQ, 32'h0000_0001);
        send_item(rqhp_pkg::OP_ENQ, 32'h0000_0002);
        send_item(rqhp_pkg::OP_PUSH, 32'h0000_0003);
        send_item(rqhp_pkg::OP_PEEK, 32'h0);
        send_item(rqhp_pkg::OP_DEQ, 32'h0);
        send_item(rqhp_pkg::OP_DEQ, 32'h0);

        set_capacity(6'd0);
        send_item(rqhp_pkg::OP_ENQ, 32'hDEAD_0001);
        send_item(rqhp_pkg::OP_PUSH, 32'hBEEF_0002);

        run_phase(6'd2, 20, 40, 70);
        hold_request = 1'b1;
        run_phase(6'd32, 30, 80, 60);
        run_phase(6'd0, 12, 50, 50);
        run_phase(6'd63, 20, 75, 90);
        run_phase(6'd5, 20, 45, 30);
        run_phase(6'd1, 12, 40, 100);
        run_phase(6'd17, 25, 55, 50);
        run_phase(6'd31, 10, 60, 80);
        repeat (10) @(posedge clk);

        $display("Summary: %0d input items over %0d capacity settings, %0d results checked.",
                 items_sent, cap_settings + 1, tracker.checked);
        $display("Summary: %0d evictions, %0d drains, %0d full refusals, %0d empty replies.",
                 tracker.evictions, tracker.drains, tracker.full_refusals,
                 tracker.empty_replies);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results still awaited", tracker.mismatches,
                     tracker.awaited_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results still awaited", tracker.awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
